### src/wrs_pkg.sv
// Shared types and constants of the water ripple simulation core.
package wrs_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CELLS    = 65536;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned MAX_ROWS = 256;
  localparam int unsigned MIN_DIM  = 5;
  localparam int unsigned TAP_W    = 4;

  // Configuration register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    K_CLEAR = 2'd0,
    K_DROP  = 2'd1,
    K_ADV   = 2'd2,
    K_READ  = 2'd3
  } kind_e;

  // Address pattern of a tap sequence
  typedef enum logic [1:0] {
    M_READ = 2'd0,
    M_WAVE = 2'd1,
    M_LP   = 2'd2,
    M_DROP = 2'd3
  } mode_e;

  typedef struct packed {
    logic  load;
    logic  wipe;
    logic  wipe_scr;
    logic  drop_wr;
    logic  tap_issue;
    logic  cell_init;
    logic  cell_next;
    logic  calc1;
    logic  calc2;
    logic  wr_cell;
    logic  swap;
    logic  lp;
    mode_e mode;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic sweep_last;
    logic tap_last;
    logic cell_last;
  } sts_t;

endpackage

### src/wrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/wrs_ctrl.sv
// Command sequencer of the ripple core: one-hot state machine.
module wrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    kind_i,
  input  wrs_pkg::sts_t sts_i,
  output wrs_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import wrs_pkg::*;

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_CLR   = 13'b0000000001000,
    S_DROP  = 13'b0000000010000,
    S_RTAP  = 13'b0000000100000,
    S_RWAIT = 13'b0000001000000,
    S_ATAP  = 13'b0000010000000,
    S_AWAIT = 13'b0000100000000,
    S_CALC1 = 13'b0001000000000,
    S_CALC2 = 13'b0010000000000,
    S_AWR   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   lp_q, lp_d;
  logic   pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      kind_q  <= K_CLEAR;
      lp_q    <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      lp_q    <= lp_d;
      pass_q  <= pass_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    lp_d    = lp_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.lp   = lp_q;
    cmd_o.mode = lp_q ? M_LP : M_WAVE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.wipe     = 1'b1;
        cmd_o.wipe_scr = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          kind_d     = kind_e'(kind_i);
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (kind_q)
          K_CLEAR: state_d = S_CLR;
          K_DROP:  state_d = sts_i.bad ? S_DONE : S_DROP;
          K_ADV: begin
            cmd_o.cell_init = 1'b1;
            lp_d            = 1'b0;
            pass_d          = 1'b0;
            state_d         = S_ATAP;
          end
          K_READ:  state_d = sts_i.bad ? S_DONE : S_RTAP;
          default: state_d = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DROP: begin
        cmd_o.mode    = M_DROP;
        cmd_o.drop_wr = 1'b1;
        if (sts_i.tap_last) state_d = S_DONE;
      end
      S_RTAP: begin
        cmd_o.mode      = M_READ;
        cmd_o.tap_issue = 1'b1;
        if (sts_i.tap_last) state_d = S_RWAIT;
      end
      S_RWAIT: state_d = S_DONE;
      S_ATAP: begin
        cmd_o.tap_issue = 1'b1;
        if (sts_i.tap_last) state_d = S_AWAIT;
      end
      S_AWAIT: state_d = S_CALC1;
      S_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d     = S_CALC2;
      end
      S_CALC2: begin
        cmd_o.calc2 = 1'b1;
        state_d     = S_AWR;
      end
      S_AWR: begin
        cmd_o.wr_cell = 1'b1;
        state_d       = S_ATAP;
        if (!sts_i.cell_last) begin
          cmd_o.cell_next = 1'b1;
        end else if (!lp_q) begin
          // wave step done, low pass over the scratch grid next
          cmd_o.cell_init = 1'b1;
          lp_d            = 1'b1;
        end else begin
          cmd_o.swap = 1'b1;
          if (!pass_q) begin
            cmd_o.cell_init = 1'b1;
            lp_d            = 1'b0;
            pass_d          = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

### src/wrs_dp.sv
// Datapath of the ripple core: height grids, address generation and arithmetic.
module wrs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrs_pkg::cmd_t       cmd_i,
  output wrs_pkg::sts_t       sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [8:0]          cfg_wdata_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          col_i,
  input  logic [7:0]          row_i,
  input  logic signed [24:0]  drop_power_i,
  output logic signed [7:0]   tilt_x_o,
  output logic signed [7:0]   tilt_y_o,
  output logic                status_o
);
  import wrs_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_W'(MIN_DIM)) return DIM_W'(MIN_DIM);
    if (v > DIM_W'(hi))      return DIM_W'(hi);
    return v;
  endfunction

  // Signed square of bits 22..15 of a difference, low 8 bits
  function automatic logic [7:0] tilt8(logic [DATA_W-1:0] d);
    logic [7:0]  i;
    logic [15:0] sq;
    i  = d[22:15];
    sq = i * i;
    return i[7] ? 8'(-sq) : sq[7:0];
  endfunction

  logic [DIM_W-1:0]  w_q, h_q;
  logic              sel_q;
  logic [ADDR_W-1:0] sweep_q;
  logic [TAP_W-1:0]  tap_q, iss_tap_q;
  logic              iss_q;
  mode_e             iss_mode_q;
  logic [ADDR_W-1:0] k_q;
  logic [7:0]        x_q, y_q;
  logic              bad_q;
  logic signed [24:0] pw_q, half_q, quarter_q;
  logic [DATA_W-1:0] c_q, p_q, res_q;
  logic signed [35:0] acc_q;
  logic signed [37:0] s_q;
  logic signed [32:0] v_q;
  logic [7:0]        tx_q, ty_q;

  logic [ADDR_W-1:0] wx, addr_tap;
  logic [TAP_W-1:0]  t_eff;
  logic              tap_last;
  logic [7:0]        x_end, y_end;
  logic              drop_bad, read_bad;
  logic [DATA_W-1:0] rd_a, rd_b, rd_s, rd_cur, rd_prv, rd_src;
  logic [DATA_W-1:0] drop_val;
  logic              we_a, we_b, we_s;
  logic [ADDR_W-1:0] wa_a, wa_b, wa_s;
  logic [DATA_W-1:0] wd_a, wd_b, wd_s;
  logic signed [37:0] c38;
  logic signed [32:0] c33, p33;
  logic [DATA_W-1:0] h32, vs32;

  // Configuration registers, stored clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= DIM_W'(MAX_COLS);
      h_q <= DIM_W'(MAX_ROWS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COLS) w_q <= clamp_dim(cfg_wdata_i, MAX_COLS);
      else                       h_q <= clamp_dim(cfg_wdata_i, MAX_ROWS);
    end
  end

  // Range checks on the incoming transaction
  assign drop_bad = (col_i < 8'd2) || ({1'b0, col_i} > w_q - 9'd3) ||
                    (row_i < 8'd2) || ({1'b0, row_i} > h_q - 9'd3);
  assign read_bad = ({1'b0, col_i} > w_q - 9'd2) || ({1'b0, row_i} > h_q - 9'd2);

  // Tap address: center, edges, then corners
  assign wx = ADDR_W'(w_q);
  always_comb begin
    t_eff = tap_q;
    if (cmd_i.mode == M_READ && tap_q == TAP_W'(1)) t_eff = TAP_W'(3);
    if (cmd_i.mode == M_READ && tap_q == TAP_W'(2)) t_eff = TAP_W'(4);
    case (t_eff)
      TAP_W'(1): addr_tap = k_q - wx;
      TAP_W'(2): addr_tap = k_q - 16'd1;
      TAP_W'(3): addr_tap = k_q + 16'd1;
      TAP_W'(4): addr_tap = k_q + wx;
      TAP_W'(5): addr_tap = k_q - wx - 16'd1;
      TAP_W'(6): addr_tap = k_q - wx + 16'd1;
      TAP_W'(7): addr_tap = k_q + wx - 16'd1;
      TAP_W'(8): addr_tap = k_q + wx + 16'd1;
      default:   addr_tap = k_q;
    endcase
    unique case (cmd_i.mode)
      M_READ:  tap_last = (tap_q == TAP_W'(2));
      M_LP:    tap_last = (tap_q == TAP_W'(4));
      default: tap_last = (tap_q == TAP_W'(8));
    endcase
  end

  always_comb begin
    if (tap_q == '0)          drop_val = DATA_W'(pw_q);
    else if (tap_q <= TAP_W'(4)) drop_val = DATA_W'(half_q);
    else                      drop_val = DATA_W'(quarter_q);
  end

  // Control counters: sweep, tap, grid swap, read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      tap_q      <= '0;
      iss_q      <= 1'b0;
      iss_tap_q  <= '0;
      iss_mode_q <= M_READ;
      sel_q      <= 1'b0;
    end else begin
      if (cmd_i.wipe) sweep_q <= sweep_q + 16'd1;
      if (cmd_i.tap_issue || cmd_i.drop_wr) begin
        tap_q <= tap_last ? '0 : tap_q + TAP_W'(1);
      end
      iss_q      <= cmd_i.tap_issue;
      iss_tap_q  <= tap_q;
      iss_mode_q <= cmd_i.mode;
      if (cmd_i.swap) sel_q <= ~sel_q;
    end
  end

  // Transaction fields, cell walk and arithmetic
  assign x_end = 8'(w_q - 9'd2);
  assign y_end = 8'(h_q - 9'd2);
  assign c38   = 38'(signed'(c_q));
  assign c33   = 33'(signed'(c_q));
  assign p33   = 33'(signed'(p_q));
  assign h32   = s_q[34:3];
  assign vs32  = {{7{v_q[32]}}, v_q[32:8]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q       <= ADDR_W'(row_i * w_q + {9'd0, col_i});
      bad_q     <= (kind_i == K_DROP) ? drop_bad : (kind_i == K_READ) ? read_bad : 1'b0;
      pw_q      <= drop_power_i;
      half_q    <= (drop_power_i + (drop_power_i[24] ? 25'sd1 : 25'sd0)) >>> 1;
      quarter_q <= (drop_power_i + (drop_power_i[24] ? 25'sd3 : 25'sd0)) >>> 2;
      tx_q      <= '0;
      ty_q      <= '0;
    end
    if (cmd_i.cell_init) begin
      k_q <= wx + 16'd1;
      x_q <= 8'd1;
      y_q <= 8'd1;
    end else if (cmd_i.cell_next) begin
      if (x_q == x_end) begin
        x_q <= 8'd1;
        y_q <= y_q + 8'd1;
        k_q <= k_q + 16'd3;
      end else begin
        x_q <= x_q + 8'd1;
        k_q <= k_q + 16'd1;
      end
    end
    // returning read data
    if (iss_q) begin
      if (iss_mode_q == M_READ) begin
        if (iss_tap_q == '0)           c_q  <= rd_cur;
        else if (iss_tap_q == TAP_W'(1)) tx_q <= tilt8(c_q - rd_cur);
        else                           ty_q <= tilt8(c_q - rd_cur);
      end else if (iss_tap_q == '0) begin
        c_q   <= rd_src;
        p_q   <= rd_prv;
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + 36'(signed'(rd_src));
      end
    end
    if (cmd_i.calc1) begin
      if (cmd_i.lp) s_q <= 38'(acc_q) + (c38 <<< 6) - (c38 <<< 2);
      else          s_q <= 38'(acc_q) - (c38 <<< 3) - c38;
      v_q <= c33 - p33;
    end
    if (cmd_i.calc2) begin
      if (cmd_i.lp) res_q <= s_q[37:6];
      else          res_q <= v_q[31:0] + h32 - vs32 + c_q;
    end
  end

  // Memory ports
  assign rd_cur = sel_q ? rd_b : rd_a;
  assign rd_prv = sel_q ? rd_a : rd_b;
  assign rd_src = (iss_mode_q == M_LP) ? rd_s : rd_cur;

  always_comb begin
    we_a = cmd_i.wipe || cmd_i.drop_wr || (cmd_i.wr_cell && cmd_i.lp && sel_q);
    we_b = cmd_i.wipe || cmd_i.drop_wr || (cmd_i.wr_cell && cmd_i.lp && !sel_q);
    we_s = (cmd_i.wipe && cmd_i.wipe_scr) || (cmd_i.wr_cell && !cmd_i.lp);
    if (cmd_i.wipe) begin
      wa_a = sweep_q;
      wd_a = '0;
    end else if (cmd_i.drop_wr) begin
      wa_a = addr_tap;
      wd_a = drop_val;
    end else begin
      wa_a = k_q;
      wd_a = res_q;
    end
    wa_b = wa_a;
    wd_b = wd_a;
    wa_s = cmd_i.wipe ? sweep_q : k_q;
    wd_s = cmd_i.wipe ? '0 : res_q;
  end

  wrs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_bank_a (
    .clk_i, .we_i(we_a), .waddr_i(wa_a), .wdata_i(wd_a), .raddr_i(addr_tap), .rdata_o(rd_a)
  );
  wrs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_bank_b (
    .clk_i, .we_i(we_b), .waddr_i(wa_b), .wdata_i(wd_b), .raddr_i(addr_tap), .rdata_o(rd_b)
  );
  wrs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_scratch (
    .clk_i, .we_i(we_s), .waddr_i(wa_s), .wdata_i(wd_s), .raddr_i(addr_tap), .rdata_o(rd_s)
  );

  assign sts_o.bad        = bad_q;
  assign sts_o.sweep_last = (sweep_q == '1);
  assign sts_o.tap_last   = tap_last;
  assign sts_o.cell_last  = (x_q == x_end) && (y_q == y_end);

  assign tilt_x_o = signed'(tx_q);
  assign tilt_y_o = signed'(ty_q);
  assign status_o = bad_q;

endmodule

### src/water_ripple_simulation_core.sv
// Top level of the water ripple height-field simulation core.
//
//  channel   ports                                        transaction when
//  command   start_i kind_i col_i row_i drop_power_i     start_i && !busy_o
//  result    done_o tilt_x_o tilt_y_o status_o           done_o (one cycle)
//  config    cfg_we_i cfg_idx_i cfg_wdata_i              cfg_we_i
//
// Clear writes one word per cycle across all 65536 addresses of both height
// banks. Advance reads each interior cell one word per cycle from the
// single-read-port grid memories.
// After reset a clearing pass zeroes all three grids; busy_o stays high
// meanwhile. done_o is high for a single cycle; tilt_x_o, tilt_y_o and
// status_o hold their values until the next command is accepted.
module water_ripple_simulation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic signed [24:0] drop_power_i,
  output logic               done_o,
  output logic signed [7:0]  tilt_x_o,
  output logic signed [7:0]  tilt_y_o,
  output logic               status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i
);
  import wrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o, .done_o
  );

  wrs_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .kind_i, .col_i, .row_i, .drop_power_i,
    .tilt_x_o, .tilt_y_o, .status_o
  );

endmodule
